[rtl/ising_metropolis_site_update_top_assert.svh]
// ---------------------------------------------------------------------------
// assertion macros for the ising site update block
// ---------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_SITE_UPDATE_TOP_ASSERT_SVH
`define ISING_METROPOLIS_SITE_UPDATE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define ISM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ism assertion failed");

// consequent checked in the cycle after the antecedent
`define ISM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ism assertion failed");

`endif

[rtl/ism_pkg.sv]
// ---------------------------------------------------------------------------
// ism_pkg
// shared widths, codes and controller interface types for the ising
// metropolis site update block
// ---------------------------------------------------------------------------
package ism_pkg;

	localparam int SIDE_DEFAULT = 32;

	localparam int COORD_IN_W = 5;
	localparam int MODE_W     = 2;
	localparam int RND_W      = 32;
	localparam int PROB_W     = 33;
	localparam int MAG_W      = 17;
	localparam int BOND_W     = 18;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 2;

	// site plus six neighbours, read in that order
	localparam int NEIGHBOURS = 6;
	localparam int RD_IDX_W   = 3;
	localparam int UPS_W      = 3;

	localparam logic [MODE_W-1:0] MODE_ATTEMPT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_NEG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_SMALL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MID   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_LARGE = 2'd3;

	// probability one, always accept
	localparam logic [PROB_W-1:0] PROB_ONE = 33'h1_0000_0000;

	typedef struct packed {
		logic sweep;
		logic capture;
		logic read;
		logic eval;
		logic commit;
	} ism_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic read_last;
	} ism_sts_t;

endpackage

[rtl/ism_ram.sv]
// ---------------------------------------------------------------------------
// ism_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module ism_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[rtl/ism_ctrl.sv]
// ---------------------------------------------------------------------------
// ism_ctrl
// sequencer: reset sweep of the spin memory, seven reads per word,
// decision, write back and output slot handshake
// ---------------------------------------------------------------------------
module ism_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ism_pkg::ism_sts_t sts,
	output ism_pkg::ism_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_SWEEP = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_WRITE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.sweep   = (state_q == ST_SWEEP);
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.read    = (state_q == ST_READ);
		cmd.eval    = (state_q == ST_EVAL);
		// write back only once the output slot is free
		cmd.commit  = (state_q == ST_WRITE) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_READ;
			end
			ST_READ: begin
				if (sts.read_last) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/ism_datapath.sv]
// ---------------------------------------------------------------------------
// ism_datapath
// spin memory, site and neighbour addressing, neighbour count, metropolis
// decision, running sums, counters and configuration registers
// ---------------------------------------------------------------------------
module ism_datapath #(
	parameter int SIDE = ism_pkg::SIDE_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ism_pkg::ism_cmd_t                 cmd,
	output ism_pkg::ism_sts_t                 sts,
	input  logic [ism_pkg::MODE_W-1:0]        mode,
	input  logic [ism_pkg::COORD_IN_W-1:0]    site_x,
	input  logic [ism_pkg::COORD_IN_W-1:0]    site_y,
	input  logic [ism_pkg::COORD_IN_W-1:0]    site_z,
	input  logic [ism_pkg::RND_W-1:0]         random_fraction,
	input  logic                              spin_value,
	input  logic                              cfg_valid,
	input  logic [ism_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ism_pkg::PROB_W-1:0]        cfg_data,
	output logic                              accepted,
	output logic                              site_spin,
	output logic signed [ism_pkg::MAG_W-1:0]  magnetization,
	output logic signed [ism_pkg::BOND_W-1:0] bond_sum,
	output logic [ism_pkg::CNT_W-1:0]         attempt_count,
	output logic [ism_pkg::CNT_W-1:0]         accept_count
);

	localparam int CW    = $clog2(SIDE);
	localparam int AW    = 3 * CW;
	localparam int DEPTH = 1 << AW;
	localparam int NTAB  = 1 << ism_pkg::COORD_IN_W;

	localparam logic [ism_pkg::MAG_W-1:0]  MAG_RESET  = ism_pkg::MAG_W'(SIDE * SIDE * SIDE);
	localparam logic [ism_pkg::BOND_W-1:0] BOND_RESET = ism_pkg::BOND_W'(3 * SIDE * SIDE * SIDE);
	localparam logic [CW-1:0]              CMAX       = CW'(SIDE - 1);

	// coordinate reduction modulo the lattice side
	logic [CW-1:0] mod_tab [NTAB];

	for (genvar g = 0; g < NTAB; g++) begin : g_mod
		localparam int REM = g % SIDE;
		assign mod_tab[g] = CW'(REM);
	end

	logic [ism_pkg::MODE_W-1:0] mode_q;
	logic [CW-1:0]              x_q, y_q, z_q;
	logic [ism_pkg::RND_W-1:0]  rnd_q;
	logic                       wval_q;

	logic                          cneg_q;
	logic [ism_pkg::PROB_W-1:0]    acc_small_q, acc_mid_q, acc_large_q;

	logic [ism_pkg::RD_IDX_W-1:0]  rd_idx_q, rd_idx_s1;
	logic                          rd_vld_s1;
	logic [AW-1:0]                 sweep_q;

	logic [ism_pkg::UPS_W-1:0]     ups_q, ups_d;
	logic                          spin_q, spin_d;
	logic                          take_q;

	logic signed [ism_pkg::MAG_W-1:0]  mag_q;
	logic signed [ism_pkg::BOND_W-1:0] bond_q;
	logic [ism_pkg::CNT_W-1:0]         att_cnt_q, acc_cnt_q;
	logic                              accepted_q, site_spin_q;

	logic [CW-1:0] xm, xp, ym, yp, zm, zp;
	logic [AW-1:0] site_addr, rd_addr, ram_addr;
	logic          ram_we, ram_wdata, ram_rdata;

	logic [ism_pkg::UPS_W-1:0]  aligned;
	logic [ism_pkg::PROB_W-1:0] thr;
	logic                       free, take;

	logic        is_att, is_wr, is_clr, flip, wb_spin;
	logic signed [5:0] bstep_raw, bstep;
	logic signed [ism_pkg::MAG_W-1:0]  mag_step;
	logic signed [ism_pkg::BOND_W-1:0] bond_step;

	assign xm = (x_q == '0) ? CMAX : x_q - 1'b1;
	assign xp = (x_q == CMAX) ? '0 : x_q + 1'b1;
	assign ym = (y_q == '0) ? CMAX : y_q - 1'b1;
	assign yp = (y_q == CMAX) ? '0 : y_q + 1'b1;
	assign zm = (z_q == '0) ? CMAX : z_q - 1'b1;
	assign zp = (z_q == CMAX) ? '0 : z_q + 1'b1;

	assign site_addr = {x_q, y_q, z_q};

	always_comb begin
		unique case (rd_idx_q)
			3'd1:    rd_addr = {xm, y_q, z_q};
			3'd2:    rd_addr = {xp, y_q, z_q};
			3'd3:    rd_addr = {x_q, ym, z_q};
			3'd4:    rd_addr = {x_q, yp, z_q};
			3'd5:    rd_addr = {x_q, y_q, zm};
			3'd6:    rd_addr = {x_q, y_q, zp};
			default: rd_addr = site_addr;
		endcase
	end

	assign ram_we    = cmd.sweep || cmd.commit;
	assign ram_wdata = cmd.sweep ? 1'b1 : wb_spin;
	assign ram_addr  = cmd.sweep ? sweep_q : (cmd.commit ? site_addr : rd_addr);

	ism_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_spin_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign sts.sweep_last = &sweep_q;
	assign sts.read_last  = (rd_idx_q == ism_pkg::RD_IDX_W'(ism_pkg::NEIGHBOURS));

	// first returned bit is the site, the rest count up neighbours
	always_comb begin
		ups_d  = ups_q;
		spin_d = spin_q;
		if (cmd.capture) begin
			ups_d = '0;
		end else if (rd_vld_s1) begin
			if (rd_idx_s1 == '0) begin
				spin_d = ram_rdata;
			end else begin
				ups_d = ups_q + ism_pkg::UPS_W'(ram_rdata);
			end
		end
	end

	// neighbours aligned with the site spin decide the energy rise
	assign aligned = spin_d ? ups_d : 3'd6 - ups_d;

	always_comb begin
		unique case (aligned)
			3'd0: begin free = cneg_q;  thr = acc_large_q; end
			3'd1: begin free = cneg_q;  thr = acc_mid_q;   end
			3'd2: begin free = cneg_q;  thr = acc_small_q; end
			3'd4: begin free = !cneg_q; thr = acc_small_q; end
			3'd5: begin free = !cneg_q; thr = acc_mid_q;   end
			3'd6: begin free = !cneg_q; thr = acc_large_q; end
			default: begin free = 1'b1; thr = acc_small_q; end
		endcase
	end

	assign take = free || ({1'b0, rnd_q} < thr);

	assign is_att   = (mode_q == ism_pkg::MODE_ATTEMPT);
	assign is_wr    = (mode_q == ism_pkg::MODE_WRITE);
	assign is_clr   = (mode_q == ism_pkg::MODE_CLEAR);
	assign flip     = (is_att && take_q) || (is_wr && (wval_q != spin_q));
	assign wb_spin  = flip ? !spin_q : spin_q;

	// bond change of a flip: 4*ups - 12 from down, the negation from up
	assign bstep_raw = $signed({1'b0, ups_q, 2'b00}) - 6'sd12;
	assign bstep     = spin_q ? -bstep_raw : bstep_raw;
	assign mag_step  = spin_q ? ism_pkg::MAG_W'(-2) : ism_pkg::MAG_W'(2);
	assign bond_step = ism_pkg::BOND_W'(bstep);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			x_q    <= mod_tab[site_x];
			y_q    <= mod_tab[site_y];
			z_q    <= mod_tab[site_z];
			rnd_q  <= random_fraction;
			wval_q <= spin_value;
		end
		ups_q  <= ups_d;
		spin_q <= spin_d;
		if (cmd.eval) begin
			take_q <= take;
		end
		if (cmd.commit) begin
			accepted_q  <= (is_att && take_q) || is_wr;
			site_spin_q <= wb_spin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_idx_s1 <= '0;
			rd_vld_s1 <= 1'b0;
			sweep_q   <= '0;
			mag_q     <= MAG_RESET;
			bond_q    <= BOND_RESET;
			att_cnt_q <= '0;
			acc_cnt_q <= '0;
		end else begin
			rd_vld_s1 <= cmd.read;
			rd_idx_s1 <= rd_idx_q;
			if (cmd.capture) begin
				rd_idx_q <= '0;
			end else if (cmd.read) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.sweep) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.commit) begin
				if (flip) begin
					mag_q  <= mag_q + mag_step;
					bond_q <= bond_q + bond_step;
				end
				if (is_clr) begin
					att_cnt_q <= '0;
					acc_cnt_q <= '0;
				end else if (is_att) begin
					if (~&att_cnt_q) att_cnt_q <= att_cnt_q + 1'b1;
					if (take_q && ~&acc_cnt_q) acc_cnt_q <= acc_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cneg_q      <= 1'b0;
			acc_small_q <= ism_pkg::PROB_ONE;
			acc_mid_q   <= ism_pkg::PROB_ONE;
			acc_large_q <= ism_pkg::PROB_ONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ism_pkg::CFG_COUPLING_NEG: cneg_q      <= cfg_data[0];
				ism_pkg::CFG_ACCEPT_SMALL: acc_small_q <= cfg_data;
				ism_pkg::CFG_ACCEPT_MID:   acc_mid_q   <= cfg_data;
				ism_pkg::CFG_ACCEPT_LARGE: acc_large_q <= cfg_data;
				default:                   cneg_q      <= cneg_q;
			endcase
		end
	end

	// sums and counters only move at write back, which waits for a free slot
	assign accepted      = accepted_q;
	assign site_spin     = site_spin_q;
	assign magnetization = mag_q;
	assign bond_sum      = bond_q;
	assign attempt_count = att_cnt_q;
	assign accept_count  = acc_cnt_q;

endmodule

[rtl/ising_metropolis_site_update_top.sv]
// ---------------------------------------------------------------------------
// ising_metropolis_site_update_top
// metropolis site update on a periodic cubic lattice of one-bit spins
// ---------------------------------------------------------------------------
// input channel (in_valid/in_ready): one word names a site, a mode, a random
// fraction and a spin; each word gives exactly one result word on the output
// channel (out_valid/out_ready). config channel (cfg_valid/cfg_ready) is
// always ready; write it only while the block is idle.
// the block works on one word at a time and takes the next one only once
// the last is written back: seven reads (site and six neighbours) and one
// write back, all through the single port spin memory, plus a decision
// state and a return to idle. the result word is registered at write back.
// one result waits in the output slot while the next word is accepted and
// read; if the receiver stalls, write back of that next word waits there.
// reset: counters clear, sums take the all-up values, config takes its
// defaults, and a sweep sets every spin to +1, one address a cycle, over all
// 2^(3*ceil(log2 SIDE)) addresses (32768 at SIDE = 32) before in_ready rises.
// ---------------------------------------------------------------------------
module ising_metropolis_site_update_top #(
	parameter int SIDE = ism_pkg::SIDE_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ism_pkg::MODE_W-1:0]        mode,
	input  logic [ism_pkg::COORD_IN_W-1:0]    site_x,
	input  logic [ism_pkg::COORD_IN_W-1:0]    site_y,
	input  logic [ism_pkg::COORD_IN_W-1:0]    site_z,
	input  logic [ism_pkg::RND_W-1:0]         random_fraction,
	input  logic                              spin_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              accepted,
	output logic                              site_spin,
	output logic signed [ism_pkg::MAG_W-1:0]  magnetization,
	output logic signed [ism_pkg::BOND_W-1:0] bond_sum,
	output logic [ism_pkg::CNT_W-1:0]         attempt_count,
	output logic [ism_pkg::CNT_W-1:0]         accept_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ism_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ism_pkg::PROB_W-1:0]        cfg_data
);

	ism_pkg::ism_cmd_t cmd;
	ism_pkg::ism_sts_t sts;

	assign cfg_ready = 1'b1;

	ism_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ism_datapath #(
		.SIDE (SIDE)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.site_x          (site_x),
		.site_y          (site_y),
		.site_z          (site_z),
		.random_fraction (random_fraction),
		.spin_value      (spin_value),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.accepted        (accepted),
		.site_spin       (site_spin),
		.magnetization   (magnetization),
		.bond_sum        (bond_sum),
		.attempt_count   (attempt_count),
		.accept_count    (accept_count)
	);

endmodule

[rtl/ism_checker.sv]
// ---------------------------------------------------------------------------
// ism_checker
// port level checks of the ising site update block, bound to the top level
// ---------------------------------------------------------------------------
`include "ising_metropolis_site_update_top_assert.svh"

module ism_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              accepted,
	input logic                              site_spin,
	input logic signed [ism_pkg::MAG_W-1:0]  magnetization,
	input logic signed [ism_pkg::BOND_W-1:0] bond_sum,
	input logic [ism_pkg::CNT_W-1:0]         attempt_count,
	input logic [ism_pkg::CNT_W-1:0]         accept_count
);

	localparam int OUT_W = 2 + ism_pkg::MAG_W + ism_pkg::BOND_W + 2 * ism_pkg::CNT_W;

	logic [OUT_W-1:0] out_word;

	assign out_word = {accepted, site_spin, magnetization, bond_sum, attempt_count,
		accept_count};

	// one word in flight: input closes right after an accept
	`ISM_ASSERT_NEXT(a_one_word_in_flight, in_valid && in_ready, !in_ready)

	// acceptances never outrun attempts, saturation included
	`ISM_ASSERT_SAME(a_accepts_le_attempts, out_valid, accept_count <= attempt_count)

	// a stalled result word holds
	`ISM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind ising_metropolis_site_update_top ism_checker u_ism_checker (.*);
